FILE: rtl/core/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the byte ring buffer with burst writes.
// ----------------------------------------------------------------------------
package brb_pkg;

    // default store depth in bytes
    localparam int BRB_DEPTH = 4096;

    // field widths of the stream items
    localparam int DATA_W = 8;
    localparam int CAP_W  = 13;
    localparam int BLEN_W = 13;
    localparam int RLEN_W = 7;
    localparam int STAT_W = 2;
    localparam int DLV_W  = 7;
    localparam int FILL_W = 13;

    // packed widths of tdata on both sides
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // longest read request served
    localparam logic [RLEN_W-1:0] MAX_READ = RLEN_W'(64);

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_ROOM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_ISSUE,
        ST_RD_DATA
    } brb_state_t;

    // operation of the shared pointer and count unit
    typedef enum logic {
        UOP_WRITE,
        UOP_READ
    } brb_uop_t;

endpackage

FILE: rtl/core/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/brb_unit.sv
// ----------------------------------------------------------------------------
// brb_unit
// Shared step unit: advances the selected pointer with wrap at the capacity
// and moves the free byte count by one.
// ----------------------------------------------------------------------------
module brb_unit
    import brb_pkg::*;
#(
    parameter int DEPTH = BRB_DEPTH
) (
    input  brb_uop_t                   op,
    input  logic [$clog2(DEPTH)-1:0]   write_ptr,
    input  logic [$clog2(DEPTH)-1:0]   read_ptr,
    input  logic [$clog2(DEPTH+1)-1:0] free_count,
    input  logic [$clog2(DEPTH+1)-1:0] capacity,
    output logic [$clog2(DEPTH)-1:0]   ptr_next,
    output logic [$clog2(DEPTH+1)-1:0] free_next
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [AW-1:0]    ptr_sel;
    logic [CNT_W:0]   ptr_inc;

    // pick the pointer that this step moves
    assign ptr_sel = (op == UOP_WRITE) ? write_ptr : read_ptr;

    // increment and wrap at the capacity
    always_comb begin
        ptr_inc = (CNT_W + 1)'(ptr_sel) + (CNT_W + 1)'(1);
        if (ptr_inc >= (CNT_W + 1)'(capacity)) begin
            ptr_next = '0;
        end else begin
            ptr_next = AW'(ptr_inc);
        end
    end

    // a stored byte takes a free slot, a read byte gives one back
    assign free_next = (op == UOP_WRITE) ? free_count - CNT_W'(1)
                                         : free_count + CNT_W'(1);

endmodule

FILE: rtl/core/byte_ring_buffer_burst_core.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst_core
// Byte ring buffer with programmable capacity, burst writes and read requests.
// ----------------------------------------------------------------------------
// Usage
// The s_ channel takes one item at a time: a write beat (tuser cmd 0) or a
// read request (tuser cmd 1). The first beat of a write burst carries the
// burst length; the whole burst is refused when it exceeds the free space.
// The m_ channel returns results: one per write beat, and one per byte for a
// read request (at most 64), tlast on the final result of each item. A read
// that yields no byte returns one empty result. Every result carries the
// fill level after it.
// Steps: a write beat result is loaded into the output register in ST_EXEC.
// A read passes ST_EXEC and then, for each byte, ST_RD_ISSUE, which gives the
// address to the store's registered read port, and ST_RD_DATA, in which the
// shared unit steps the read pointer and the byte is loaded as a result. The
// next request is taken in the cycle after the last result of the current one
// is loaded, if no cfg request is waiting.
// The cfg channel sets the capacity (0 is taken as 1, above DEPTH as DEPTH)
// and empties the buffer; it is taken while the block is idle.
// Reset empties the buffer and sets the capacity to DEPTH; the store itself
// is not cleared. A stalled receiver holds the result and each state that loads one.
// ----------------------------------------------------------------------------
module byte_ring_buffer_burst_core
    import brb_pkg::*;
#(
    parameter int DEPTH = BRB_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // cfg write channel: capacity
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAP_W-1:0]     cfg_data,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // data_in[7:0], burst_len[20:8],
                                           // rd_len[27:21], zero pad
    input  logic [1:0]           s_tuser,  // cmd[0], first_beat[1]
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // data_out[7:0], delivered[14:8],
                                           // fill_level[27:15], zero pad
    output logic [STAT_W-1:0]    m_tuser,  // status[1:0]
    output logic                 m_tlast
);

    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > BLEN_W) ? CNT_W : BLEN_W;
    localparam int PAD_W  = M_TDATA_W - DATA_W - DLV_W - FILL_W;

    // sequencer state
    brb_state_t state_reg, state_next;

    // latched request
    logic              cmd_reg;
    logic              first_reg;
    logic [DATA_W-1:0] din_reg;
    logic [BLEN_W-1:0] blen_reg;
    logic [RLEN_W-1:0] rlen_reg;

    // buffer state
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [AW-1:0]     wptr_reg, wptr_next;
    logic [AW-1:0]     rptr_reg, rptr_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [RLEN_W-1:0] n_reg, n_next;
    logic [RLEN_W-1:0] cnt_reg, cnt_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic [STAT_W-1:0] m_stat_reg, m_stat_next;
    logic [DLV_W-1:0]  m_dlv_reg, m_dlv_next;
    logic              m_last_reg, m_last_next;
    logic [FILL_W-1:0] m_fill_reg, m_fill_next;

    // control and datapath wires
    logic              out_free;
    logic              s_acc;
    logic              cfg_acc;
    logic              ram_we;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;
    brb_uop_t          uop;
    logic [AW-1:0]     u_ptr_next;
    logic [CNT_W-1:0]  u_free_next;
    logic              do_store;
    logic [STAT_W-1:0] wr_stat;
    logic [CNT_W-1:0]  fill_cur;
    logic [RLEN_W-1:0] rlen_clip;
    logic [RLEN_W-1:0] n_calc;
    logic [RLEN_W-1:0] cnt_inc;
    logic [CNT_W-1:0]  cap_cfg;

    assign out_free = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_acc  = cfg_valid && cfg_ready;
    assign fill_cur = cap_reg - free_reg;
    assign cnt_inc  = cnt_reg + RLEN_W'(1);

    // byte store
    brb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (din_reg),
        .re    (ram_re),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    // shared pointer and free count step
    brb_unit #(
        .DEPTH (DEPTH)
    ) u_step (
        .op         (uop),
        .write_ptr  (wptr_reg),
        .read_ptr   (rptr_reg),
        .free_count (free_reg),
        .capacity   (cap_reg),
        .ptr_next   (u_ptr_next),
        .free_next  (u_free_next)
    );

    // write beat decision
    always_comb begin
        do_store = 1'b0;
        wr_stat  = STAT_OK;
        if (first_reg) begin
            if (blen_reg == '0) begin
                wr_stat = STAT_OK;
            end else if (CMP_W'(blen_reg) > CMP_W'(free_reg)) begin
                wr_stat = STAT_NO_ROOM;
            end else begin
                do_store = 1'b1;
            end
        end else if (left_reg != '0) begin
            do_store = 1'b1;
        end else begin
            wr_stat = STAT_NO_ROOM;
        end
    end

    // read length: clip to the maximum and to the fill level
    always_comb begin
        rlen_clip = (rlen_reg > MAX_READ) ? MAX_READ : rlen_reg;
        if (CMP_W'(fill_cur) < CMP_W'(rlen_clip)) begin
            n_calc = RLEN_W'(fill_cur);
        end else begin
            n_calc = rlen_clip;
        end
    end

    // capacity clamp for a cfg request
    always_comb begin
        if (cfg_data == '0) begin
            cap_cfg = CNT_W'(1);
        end else if (CMP_W'(cfg_data) > CMP_W'(DEPTH)) begin
            cap_cfg = CNT_W'(DEPTH);
        end else begin
            cap_cfg = CNT_W'(cfg_data);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    if (cmd_reg == CMD_READ && n_calc != '0) begin
                        state_next = ST_RD_ISSUE;
                    end else if (cmd_reg == CMD_WRITE || n_calc == '0) begin
                        state_next = ST_IDLE;
                    end
                end else if (cmd_reg == CMD_READ && n_calc != '0) begin
                    state_next = ST_RD_ISSUE;
                end
            end
            ST_RD_ISSUE: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                if (out_free) begin
                    state_next = (cnt_inc == n_reg) ? ST_IDLE : ST_RD_ISSUE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        cfg_ready = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        uop       = UOP_WRITE;
        case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_tready  = !cfg_valid;
            end
            ST_EXEC: begin
                uop    = (cmd_reg == CMD_READ) ? UOP_READ : UOP_WRITE;
                ram_we = out_free && cmd_reg == CMD_WRITE && do_store && free_reg != '0;
            end
            ST_RD_ISSUE: begin
                ram_re = 1'b1;
                uop    = UOP_READ;
            end
            ST_RD_DATA: begin
                uop = UOP_READ;
            end
            default: begin
                uop = UOP_WRITE;
            end
        endcase
    end

    // datapath and result next values
    always_comb begin
        cap_next     = cap_reg;
        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        free_next    = free_reg;
        left_next    = left_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_stat_next  = m_stat_reg;
        m_dlv_next   = m_dlv_reg;
        m_last_next  = m_last_reg;
        m_fill_next  = m_fill_reg;

        // capacity write empties the buffer
        if (cfg_acc) begin
            cap_next  = cap_cfg;
            wptr_next = '0;
            rptr_next = '0;
            free_next = cap_cfg;
            left_next = '0;
        end

        case (state_reg)
            ST_EXEC: begin
                if (cmd_reg == CMD_WRITE) begin
                    if (out_free) begin
                        if (first_reg) begin
                            left_next = (wr_stat == STAT_OK && do_store)
                                        ? CNT_W'(blen_reg) : '0;
                        end
                        m_fill_next = FILL_W'(fill_cur);
                        if (ram_we) begin
                            wptr_next   = u_ptr_next;
                            free_next   = u_free_next;
                            left_next   = (first_reg ? CNT_W'(blen_reg) : left_reg)
                                          - CNT_W'(1);
                            m_fill_next = FILL_W'(cap_reg - u_free_next);
                        end
                        m_valid_next = 1'b1;
                        m_data_next  = '0;
                        m_stat_next  = wr_stat;
                        m_dlv_next   = '0;
                        m_last_next  = 1'b1;
                    end
                end else begin
                    n_next   = n_calc;
                    cnt_next = '0;
                    if (n_calc == '0 && out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '0;
                        m_stat_next  = (fill_cur == '0) ? STAT_EMPTY : STAT_OK;
                        m_dlv_next   = '0;
                        m_last_next  = 1'b1;
                        m_fill_next  = FILL_W'(fill_cur);
                    end
                end
            end
            ST_RD_DATA: begin
                if (out_free) begin
                    rptr_next    = u_ptr_next;
                    free_next    = u_free_next;
                    cnt_next     = cnt_inc;
                    m_valid_next = 1'b1;
                    m_data_next  = ram_rdata;
                    m_stat_next  = STAT_OK;
                    m_dlv_next   = DLV_W'(cnt_inc);
                    m_last_next  = (cnt_inc == n_reg);
                    m_fill_next  = FILL_W'(cap_reg - u_free_next);
                end
            end
            default: begin
                n_next = n_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CNT_W'(DEPTH);
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            free_reg    <= CNT_W'(DEPTH);
            left_reg    <= '0;
            n_reg       <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            wptr_reg    <= wptr_next;
            rptr_reg    <= rptr_next;
            free_reg    <= free_next;
            left_reg    <= left_next;
            n_reg       <= n_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg   <= s_tuser[0];
            first_reg <= s_tuser[1];
            din_reg   <= s_tdata[DATA_W-1:0];
            blen_reg  <= s_tdata[DATA_W+BLEN_W-1:DATA_W];
            rlen_reg  <= s_tdata[DATA_W+BLEN_W+RLEN_W-1:DATA_W+BLEN_W];
        end
        m_data_reg <= m_data_next;
        m_stat_reg <= m_stat_next;
        m_dlv_reg  <= m_dlv_next;
        m_last_reg <= m_last_next;
        m_fill_reg <= m_fill_next;
    end

    // result channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_fill_reg, m_dlv_reg, m_data_reg};
    assign m_tuser  = m_stat_reg;
    assign m_tlast  = m_last_reg;

endmodule
